@@ src/char_lcd_nibble_bus_controller_top_macros.svh @@
// Assertion macros for the character LCD nibble bus controller.
`ifndef CHAR_LCD_NIBBLE_BUS_CONTROLLER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_BUS_CONTROLLER_TOP_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define LCDNB_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition never holds on any clock edge outside reset.
`define LCDNB_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ src/lcdnb_pkg.sv @@
// Shared types, constants and the line address map for the LCD nibble bus controller.
`default_nettype none
package lcdnb_pkg;

   localparam logic [15:0] DEVICE_ADDRESS_RESET = 16'hC000;
   localparam logic [7:0]  SPACE_CHAR           = 8'h20;
   localparam logic [7:0]  CMD_CLEAR            = 8'h01;
   localparam logic [3:0]  NIB_8BIT_MODE        = 4'h3;
   localparam logic [3:0]  NIB_4BIT_MODE        = 4'h2;
   localparam int          CLK_BIT              = 7;
   localparam int          RS_BIT               = 6;
   localparam logic [7:0]  LINE_LEN             = 8'd20;
   localparam logic [7:0]  LINE2_BASE           = 8'd64;
   localparam logic [7:0]  LINE4_BASE           = 8'd84;
   localparam logic [7:0]  LINE3_POS            = 8'd40;
   localparam logic [7:0]  LINE4_POS            = 8'd60;

   // One memory update produced by a bus write transaction.
   typedef struct packed {
      logic       wr;
      logic [6:0] pos;
      logic [7:0] chr;
      logic       clr;
   } lcdnb_write_type;

   // Map a display line address (4x20 layout) to a linear cursor position.
   function automatic logic [7:0] map_line(input logic [6:0] a);
      logic [7:0] w;
      w = {1'b0, a};
      if (w < LINE_LEN) begin
         return w;
      end else if (w >= LINE2_BASE && w < LINE4_BASE) begin
         return w - LINE2_BASE + LINE_LEN;
      end else if (w < LINE2_BASE) begin
         return w - LINE_LEN + LINE3_POS;
      end else begin
         return w - LINE4_BASE + LINE4_POS;
      end
   endfunction

endpackage
`default_nettype wire

@@ src/char_lcd_nibble_bus_controller_top.sv @@
// Top level of the character LCD nibble bus controller.
// A transaction is accepted in idle, runs the execute step (which issues the registered
// display memory read), then loads its result into the output register, holding there
// while the output is full. No new transaction is accepted until the result is loaded.
// Reset (synchronous, active high) returns the address register to 0xC000,
// clears bus state and cursor, and drops all display valid flags (all spaces).
`default_nettype none
`include "char_lcd_nibble_bus_controller_top_macros.svh"
module char_lcd_nibble_bus_controller_top
   import lcdnb_pkg::*;
#(
   parameter int DISPLAY_CHARS = 80
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [15:0] req_bus_address,
   input  wire logic [7:0]  req_bus_data,
   input  wire logic [6:0]  req_read_index,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_char,
   output logic             rsp_char_written,
   output logic [6:0]       rsp_written_pos,
   output logic [7:0]       rsp_written_char,
   output logic             rsp_display_cleared,
   output logic [7:0]       rsp_cursor_position
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD
   } state_type;

   state_type       state_ff;
   logic [15:0]     dev_addr_ff;

   // transaction captured at accept
   logic            cmd_ff;
   logic [15:0]     addr_ff;
   logic [7:0]      data_ff;
   logic [6:0]      idx_ff;

   // memory update held from the execute step for the response
   lcdnb_write_type wres_ff;

   // response output register
   logic            rsp_valid_ff;
   logic [7:0]      rsp_read_char_ff;
   lcdnb_write_type rsp_wres_ff;
   logic [7:0]      rsp_cursor_ff;

   logic            req_accept;
   logic            exec_wr;
   logic            exec_rd;
   logic            slot_free;
   lcdnb_write_type dec_wres;
   lcdnb_write_type mem_wr;
   logic [7:0]      cursor;
   logic [7:0]      rd_data;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;

   // Execute step: bus writes update decoder state and memory, reads issue the RAM read.
   assign exec_wr   = state_ff == ST_EXEC && !cmd_ff;
   assign exec_rd   = state_ff == ST_EXEC && cmd_ff;
   assign mem_wr    = exec_wr ? dec_wres : '0;
   // The output register may take a new result when empty or when drained this cycle.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= DEVICE_ADDRESS_RESET;
      end else if (csr_wr_en) begin
         dev_addr_ff <= csr_wr_data;
      end
   end

   lcdnb_decode #(
      .DISPLAY_CHARS(DISPLAY_CHARS)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .exec        (exec_wr),
      .dev_addr    (dev_addr_ff),
      .bus_address (addr_ff),
      .bus_data    (data_ff),
      .wres        (dec_wres),
      .cursor      (cursor)
   );

   lcdnb_mem #(
      .DISPLAY_CHARS(DISPLAY_CHARS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .rd_en   (exec_rd),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Sequencer: idle -> execute -> load result, holding in load while the output is full.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  cmd_ff   <= req_command;
                  addr_ff  <= req_bus_address;
                  data_ff  <= req_bus_data;
                  idx_ff   <= req_read_index;
                  state_ff <= ST_EXEC;
               end
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               wres_ff  <= mem_wr;
               state_ff <= ST_LOAD;
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_LOAD: begin
               if (slot_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_read_char_ff <= cmd_ff ? rd_data : 8'h00;
                  rsp_wres_ff      <= wres_ff;
                  rsp_cursor_ff    <= cursor;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_char       = rsp_read_char_ff;
   assign rsp_char_written    = rsp_wres_ff.wr;
   assign rsp_written_pos     = rsp_wres_ff.pos;
   assign rsp_written_char    = rsp_wres_ff.chr;
   assign rsp_display_cleared = rsp_wres_ff.clr;
   assign rsp_cursor_position = rsp_cursor_ff;

   `LCDNB_ASSERT_NEVER(a_no_write_and_clear, mem_wr.wr && mem_wr.clr,
      "memory write and clear in the same cycle")
   `LCDNB_ASSERT_IMPL(a_accept_to_exec, req_accept, ##1 state_ff == ST_EXEC,
      "accepted transaction did not enter the execute step")
   `LCDNB_ASSERT_IMPL(a_read_no_update, exec_rd, mem_wr == '0,
      "display read transaction modified the memory")

endmodule
`default_nettype wire

@@ src/lcdnb_mem.sv @@
// Display character memory with per-entry valid flags and a registered read port.
`default_nettype none
module lcdnb_mem
   import lcdnb_pkg::*;
#(
   parameter int DISPLAY_CHARS = 80
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire lcdnb_write_type wr,
   input  wire logic            rd_en,
   input  wire logic [6:0]      rd_addr,
   output logic [7:0]           rd_data
);
   localparam int          AW     = (DISPLAY_CHARS > 1) ? $clog2(DISPLAY_CHARS) : 1;
   localparam logic [7:0]  DEPTH  = 8'(DISPLAY_CHARS);

   logic [7:0] mem_ff [DISPLAY_CHARS];
   logic       valid_ff [DISPLAY_CHARS];
   logic [7:0] rd_word_ff;
   logic       rd_valid_ff;
   logic       rd_inrange_ff;
   logic       rd_inrange_in;

   assign rd_inrange_in = {1'b0, rd_addr} < DEPTH;

   always_ff @(posedge clock) begin
      if (wr.wr) begin
         mem_ff[wr.pos[AW-1:0]] <= wr.chr;
      end
      if (rd_en) begin
         rd_word_ff    <= mem_ff[rd_addr[AW-1:0]];
         rd_valid_ff   <= valid_ff[rd_addr[AW-1:0]];
         rd_inrange_ff <= rd_inrange_in;
      end
   end

   // Drop all valid flags on reset or clear; an invalid entry reads as a space.
   always_ff @(posedge clock) begin
      if (reset || wr.clr) begin
         for (int i = 0; i < DISPLAY_CHARS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr.wr) begin
         valid_ff[wr.pos[AW-1:0]] <= 1'b1;
      end
   end

   assign rd_data = !rd_inrange_ff ? 8'h00 : (rd_valid_ff ? rd_word_ff : SPACE_CHAR);

endmodule
`default_nettype wire

@@ src/lcdnb_decode.sv @@
// Nibble bus protocol decoder: clock edge detect, nibble pairing, cursor and mode state.
`default_nettype none
module lcdnb_decode
   import lcdnb_pkg::*;
#(
   parameter int DISPLAY_CHARS = 80
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            exec,
   input  wire logic [15:0]     dev_addr,
   input  wire logic [15:0]     bus_address,
   input  wire logic [7:0]      bus_data,
   output lcdnb_write_type      wres,
   output logic [7:0]           cursor
);
   localparam logic [7:0] DEPTH = 8'(DISPLAY_CHARS);

   logic [7:0] prev_ff, prev_in;
   logic       await_ff, await_in;
   logic       mode_ff, mode_in;
   logic [3:0] held_ff, held_in;
   logic [7:0] cursor_ff, cursor_in;
   logic       rise;
   logic [3:0] nib;
   logic [7:0] full;

   assign rise = !prev_ff[CLK_BIT] && bus_data[CLK_BIT];
   assign nib  = bus_data[3:0];
   assign full = {held_ff, nib};

   always_comb begin
      prev_in   = prev_ff;
      await_in  = await_ff;
      mode_in   = mode_ff;
      held_in   = held_ff;
      cursor_in = cursor_ff;
      wres      = '0;
      if (bus_address == dev_addr) begin
         prev_in = bus_data;
         if (rise) begin
            if (bus_data[RS_BIT]) begin
               if (await_ff) begin
                  if (cursor_ff < DEPTH) begin
                     wres.wr  = 1'b1;
                     wres.pos = cursor_ff[6:0];
                     wres.chr = full;
                  end
                  cursor_in = cursor_ff + 8'd1;
               end else begin
                  held_in = nib;
               end
               await_in = !await_ff;
            end else if (await_ff) begin
               if (full == CMD_CLEAR) begin
                  wres.clr = 1'b1;
               end else if (full[7]) begin
                  cursor_in = map_line(full[6:0]);
               end
               await_in = 1'b0;
            end else if (nib == NIB_8BIT_MODE) begin
               mode_in = 1'b0;
            end else if (nib == NIB_4BIT_MODE) begin
               if (mode_ff) begin
                  held_in  = NIB_4BIT_MODE;
                  await_in = 1'b1;
               end else begin
                  mode_in = 1'b1;
               end
            end else if (mode_ff) begin
               held_in  = nib;
               await_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         await_ff  <= 1'b0;
         mode_ff   <= 1'b0;
         held_ff   <= '0;
         cursor_ff <= '0;
      end else if (exec) begin
         prev_ff   <= prev_in;
         await_ff  <= await_in;
         mode_ff   <= mode_in;
         held_ff   <= held_in;
         cursor_ff <= cursor_in;
      end
   end

   assign cursor = cursor_ff;

endmodule
`default_nettype wire

@@ test/char_lcd_nibble_bus_controller_top_test.sv @@
// Self-checking testbench for the character LCD nibble bus controller top level.
`timescale 1ns / 100ps
module char_lcd_nibble_bus_controller_top_test;
   import lcdnb_pkg::*;

   localparam int DISPLAY_LEN    = 80;
   localparam int SET_CURSOR_BIT = 7;       // command byte bit that selects a line address
   localparam int CYCLE_LIMIT    = 500000;  // generous ceiling on the whole run
   localparam int SETTLE_CYCLES  = 12;      // drain time after the last response

   // One response transaction as the display port reports it.
   typedef struct packed {
      logic [7:0] read_char;
      logic       stored;
      logic [6:0] pos;
      logic [7:0] chr;
      logic       cleared;
      logic [7:0] cursor;
   } panel_reply_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [15:0] req_bus_address;
   logic [7:0]  req_bus_data;
   logic [6:0]  req_read_index;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_read_char;
   logic        rsp_char_written;
   logic [6:0]  rsp_written_pos;
   logic [7:0]  rsp_written_char;
   logic        rsp_display_cleared;
   logic [7:0]  rsp_cursor_position;

   // Shadow of the display port: bus snooping state, cursor and character memory.
   logic [15:0] port_address;
   logic [7:0]  prev_byte;
   logic        low_pending;
   logic        four_bit;
   logic [3:0]  high_nib;
   logic [7:0]  cursor_pos;
   logic [7:0]  screen [DISPLAY_LEN];

   // Responses owed by the block, oldest first.
   panel_reply_type panel_replies[$];

   int  fail_count;
   int  cycle_count;
   int  accesses_counted;
   int  reads_sent;
   int  chars_stored;
   int  clears_seen;
   int  hold_left;
   bit  tx_idling;
   bit  rsp_idling;

   char_lcd_nibble_bus_controller_top #(
      .DISPLAY_CHARS(DISPLAY_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_bus_address(req_bus_address),
      .req_bus_data(req_bus_data),
      .req_read_index(req_read_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_char(rsp_read_char),
      .rsp_char_written(rsp_char_written),
      .rsp_written_pos(rsp_written_pos),
      .rsp_written_char(rsp_written_char),
      .rsp_display_cleared(rsp_display_cleared),
      .rsp_cursor_position(rsp_cursor_position)
   );

   // 2 ns clock: high for 1 ns, low for 1 ns.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run; the limit leaves a wide margin over the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("char_lcd_nibble_bus_controller_top verification failed");
         $finish;
      end
   end

   // Translate a 4x20 line address into a linear cursor position.
   function automatic logic [7:0] line_to_cursor(input logic [6:0] line_addr);
      logic [7:0] a;
      a = {1'b0, line_addr};
      if (a >= 8'd84) return a - 8'd24;   // fourth line: 84..127 -> 60..103
      if (a >= 8'd64) return a - 8'd44;   // second line: 64..83 -> 20..39
      if (a >= 8'd20) return a + 8'd20;   // third line: 20..63 -> 40..83
      return a;                           // first line maps straight through
   endfunction

   // Advance the shadow port by one access and return the response it owes.
   function automatic panel_reply_type apply_bus_access(input logic cmd,
                                                        input logic [15:0] addr,
                                                        input logic [7:0] data,
                                                        input logic [6:0] idx);
      panel_reply_type r;
      logic [7:0]      full;
      r = '0;
      if (cmd) begin
         // Read: no state moves; positions past the display read as zero.
         if (idx < DISPLAY_LEN) r.read_char = screen[idx];
      end else if (addr == port_address) begin
         // Act only on a rising edge of the bus clock bit.
         if (!prev_byte[CLK_BIT] && data[CLK_BIT]) begin
            if (data[RS_BIT]) begin
               if (low_pending) begin
                  // Store only inside the display, but move the cursor either way.
                  if (cursor_pos < DISPLAY_LEN) begin
                     screen[cursor_pos] = {high_nib, data[3:0]};
                     r.stored = 1'b1;
                     r.pos    = cursor_pos[6:0];
                     r.chr    = {high_nib, data[3:0]};
                  end
                  cursor_pos = cursor_pos + 8'd1;
               end else begin
                  high_nib = data[3:0];
               end
               low_pending = !low_pending;
            end else if (low_pending) begin
               full = {high_nib, data[3:0]};
               if (full == CMD_CLEAR) begin
                  foreach (screen[i]) screen[i] = SPACE_CHAR;
                  r.cleared = 1'b1;
               end else if (full[SET_CURSOR_BIT]) begin
                  cursor_pos = line_to_cursor(full[6:0]);
               end
               low_pending = 1'b0;
            end else if (data[3:0] == NIB_8BIT_MODE) begin
               four_bit = 1'b0;
            end else if (data[3:0] == NIB_4BIT_MODE) begin
               // Second 0x2 in nibble mode opens a byte with high nibble 0x2.
               if (four_bit) begin
                  high_nib    = NIB_4BIT_MODE;
                  low_pending = 1'b1;
               end else begin
                  four_bit = 1'b1;
               end
            end else if (four_bit) begin
               high_nib    = data[3:0];
               low_pending = 1'b1;
            end
         end
         prev_byte = data;
      end
      r.cursor = cursor_pos;
      return r;
   endfunction

   // Offer one transaction, hold it until accepted, then record what it owes.
   task automatic send_access(input logic cmd, input logic [15:0] addr,
                              input logic [7:0] data, input logic [6:0] idx);
      int gap;
      gap = 0;
      if (tx_idling && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 18);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_bus_address <= addr;
      req_bus_data    <= data;
      req_read_index  <= idx;
      do @(posedge clock); while (req_stall);
      if (cmd || addr == port_address) accesses_counted++;
      if (cmd) reads_sent++;
      panel_replies.push_back(apply_bus_access(cmd, addr, data, idx));
   endtask

   task automatic bus_write(input logic [15:0] addr, input logic [7:0] data);
      send_access(1'b0, addr, data, 7'($urandom_range(0, 127)));
   endtask

   task automatic read_char_at(input logic [6:0] idx);
      send_access(1'b1, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), idx);
   endtask

   // One nibble on the port: clock low with junk, then clock high with the nibble.
   task automatic put_nibble(input logic rs, input logic [3:0] nib);
      bus_write(port_address, 8'($urandom_range(0, 127)));
      bus_write(port_address, {1'b1, rs, 2'($urandom_range(0, 3)), nib});
   endtask

   task automatic put_data_byte(input logic [7:0] c);
      put_nibble(1'b1, c[7:4]);
      put_nibble(1'b1, c[3:0]);
   endtask

   task automatic put_command_byte(input logic [7:0] c);
      put_nibble(1'b0, c[7:4]);
      put_nibble(1'b0, c[3:0]);
   endtask

   // Usual power-up sequence: three 0x3 nibbles then 0x2 to enter nibble mode.
   task automatic put_init_sequence();
      repeat (3) put_nibble(1'b0, NIB_8BIT_MODE);
      put_nibble(1'b0, NIB_4BIT_MODE);
   endtask

   // Write the port address register once the block has drained.
   task automatic set_port_address(input logic [15:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (panel_replies.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      port_address = value;
   endtask

   // Receiver: stall in random bursts, or hold off for a counted stretch on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (rsp_idling && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18) - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Compare each accepted response against the oldest owed one.
   always @(posedge clock) begin
      panel_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (panel_replies.size() == 0) begin
            $error("response transaction with nothing outstanding");
            fail_count++;
         end else begin
            want = panel_replies.pop_front();
            check_field("read_char", want.read_char, rsp_read_char);
            check_field("char_written", 8'(want.stored), 8'(rsp_char_written));
            check_field("written_pos", 8'(want.pos), 8'(rsp_written_pos));
            check_field("written_char", want.chr, rsp_written_char);
            check_field("display_cleared", 8'(want.cleared), 8'(rsp_display_cleared));
            check_field("cursor_position", want.cursor, rsp_cursor_position);
            if (rsp_char_written) chars_stored++;
            if (rsp_display_cleared) clears_seen++;
         end
      end
   end

   // Reads of blank and out-of-range cells, foreign addresses, and a held clock bit.
   task automatic test_reads_and_ignored();
      read_char_at(7'd0);
      read_char_at(7'd127);
      bus_write(~port_address, 8'hFF);
      bus_write(port_address, 8'hCF);   // rising clock, data high nibble
      bus_write(port_address, 8'hC5);   // clock still high: only the byte is kept
   endtask

   // Data nibbles pair even before nibble mode is entered.
   task automatic test_nibble_pairing();
      put_nibble(1'b1, 4'h1);
      read_char_at(7'd0);
      read_char_at(7'd79);
   endtask

   // 0x3 leaves nibble mode, 0x2 enters it, a second 0x2 starts a byte.
   task automatic test_mode_entry();
      put_nibble(1'b0, NIB_8BIT_MODE);
      put_nibble(1'b0, NIB_4BIT_MODE);
      put_nibble(1'b0, NIB_4BIT_MODE);
      put_nibble(1'b0, 4'h8);
   endtask

   // Line three mapping, then a line four address beyond the display.
   task automatic test_cursor_mapping();
      put_command_byte(8'hA8);
      put_command_byte(8'hFF);
      put_data_byte(8'h5A);
   endtask

   task automatic test_clear();
      put_command_byte(CMD_CLEAR);
      read_char_at(7'd0);
   endtask

   // Hold off the receiver while the sender keeps offering, so the block backs up.
   task automatic test_backpressure();
      tx_idling  = 1'b0;
      rsp_idling = 1'b0;
      hold_left  = 250;
      repeat (6) begin
         put_data_byte(8'($urandom_range(0, 255)));
         read_char_at(7'($urandom_range(0, 79)));
      end
   endtask

   // Park the cursor past the display and write until it wraps back to zero.
   task automatic test_cursor_wrap();
      put_init_sequence();
      put_command_byte(8'hFF);
      repeat (160) put_data_byte(8'($urandom_range(0, 255)));
      read_char_at(7'd3);
   endtask

   // Mostly well-formed nibble traffic with random content, plus noise and broken edges.
   task automatic test_random_traffic(input int target, input bit allow_idling);
      int          kind;
      logic [15:0] addr;
      tx_idling  = allow_idling;
      rsp_idling = allow_idling;
      while (accesses_counted < target) begin
         if ($urandom_range(0, 39) == 0) begin
            tx_idling  = allow_idling && $urandom_range(0, 1);
            rsp_idling = allow_idling && $urandom_range(0, 1);
         end
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            repeat ($urandom_range(1, 6)) put_data_byte(8'($urandom_range(0, 255)));
         end else if (kind < 42) begin
            put_command_byte({1'b1, 7'($urandom_range(0, 127))});
         end else if (kind < 46) begin
            put_command_byte(CMD_CLEAR);
         end else if (kind < 52) begin
            put_init_sequence();
         end else if (kind < 56) begin
            put_nibble(1'b0, 4'($urandom_range(0, 15)));
         end else if (kind < 64) begin
            put_command_byte(8'($urandom_range(0, 255)));
         end else if (kind < 80) begin
            if ($urandom_range(0, 3) == 0) read_char_at(7'($urandom_range(80, 127)));
            else read_char_at(7'($urandom_range(0, 79)));
         end else if (kind < 90) begin
            // Foreign address: fully random or one bit away from the port.
            addr = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 1)) addr = port_address ^ (16'd1 << $urandom_range(0, 15));
            bus_write(addr, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 3)) bus_write(port_address, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      // Drive every input to a known value before the first edge.
      clock           = 1'b0;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_valid       = 1'b0;
      req_command     = 1'b0;
      req_bus_address = '0;
      req_bus_data    = '0;
      req_read_index  = '0;
      rsp_stall       = 1'b0;
      fail_count       = 0;
      cycle_count      = 0;
      accesses_counted = 0;
      reads_sent       = 0;
      chars_stored     = 0;
      clears_seen      = 0;
      hold_left        = 0;
      tx_idling        = 1'b1;
      rsp_idling       = 1'b1;
      // Shadow state after reset.
      port_address = DEVICE_ADDRESS_RESET;
      prev_byte    = '0;
      low_pending  = 1'b0;
      four_bit     = 1'b0;
      high_nib     = '0;
      cursor_pos   = '0;
      foreach (screen[i]) screen[i] = SPACE_CHAR;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed cases at the reset port address.
      test_reads_and_ignored();
      test_nibble_pairing();
      test_mode_entry();
      test_cursor_mapping();
      test_clear();
      test_backpressure();

      // Sweep the port address through its extremes between traffic phases.
      set_port_address(16'h0000);
      test_cursor_wrap();
      test_random_traffic(1050, 1'b1);
      set_port_address(16'hFFFF);
      test_random_traffic(1200, 1'b1);
      set_port_address(16'($urandom_range(0, 65535)));
      test_random_traffic(1380, 1'b1);
      // Finish back at the reset address with both sides running flat out.
      set_port_address(DEVICE_ADDRESS_RESET);
      test_random_traffic(1650, 1'b0);

      // Drop valid, drain the outstanding responses, then let the pipeline settle.
      @(negedge clock);
      req_valid <= 1'b0;
      while (panel_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d port accesses: %0d reads, %0d characters stored, %0d clears",
               accesses_counted, reads_sent, chars_stored, clears_seen);
      $display("across several port addresses, a cursor wrap and one long receiver hold-off");
      if (fail_count == 0) begin
         $display("char_lcd_nibble_bus_controller_top verification clean");
      end else begin
         $display("char_lcd_nibble_bus_controller_top verification failed");
      end
      $finish;
   end

endmodule
